FILE: sv/psla_pkg.sv
`default_nettype none
// ============================================================================
// psla_pkg: shared types, constants and functions
// Widths, register indexes, fixed-point helpers and the bias-correction
// tables of the per-synapse learning rate adapter.
// ============================================================================
package psla_pkg;

    localparam int NUM_SYNAPSES = 1024;
    localparam int IDX_W        = $clog2(NUM_SYNAPSES);
    localparam int HISTORY_MAX  = 64;
    localparam int HIST_W       = 7;
    localparam int Q_W          = 32;
    localparam int CFG_W        = 25;
    localparam int ALG_W        = 2;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTATION_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABILITY_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE            = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE           = 3'd5;

    localparam logic [ALG_W-1:0] ALG_RMSPROP     = 2'd0;
    localparam logic [ALG_W-1:0] ALG_ADAM        = 2'd1;
    localparam logic [ALG_W-1:0] ALG_HOMEOSTATIC = 2'd2;

    localparam logic [CFG_W-1:0] ADAPT_RESET = 25'd167772;
    localparam logic [CFG_W-1:0] THR_RESET   = 25'd8388608;
    localparam logic [CFG_W-1:0] MAX_RESET   = 25'd1677722;
    localparam logic [CFG_W-1:0] MIN_RESET   = 25'd1678;
    localparam logic [CFG_W-1:0] BASE_RESET  = 25'd167772;

    typedef logic signed [67:0] wide_t;
    typedef logic signed [Q_W-1:0] q_t;
    typedef logic signed [33:0] opnd_t;

    localparam opnd_t ONE_Q  = 34'sd16777216;
    localparam opnd_t TWO_Q  = 34'sd33554432;
    localparam opnd_t K_09   = 34'sd15099494;
    localparam opnd_t K_01   = 34'sd1677722;
    localparam opnd_t K_0999 = 34'sd16760439;
    localparam opnd_t K_0001 = 34'sd16777;
    localparam q_t    RATE_RESET = 32'sd167772;

    typedef logic [24:0] bias_tab_t [0:HISTORY_MAX];

    function automatic q_t sat32(wide_t x);
        q_t y;
        if (x > 68'sd2147483647)
            y = 32'sh7fffffff;
        else if (x < -68'sd2147483648)
            y = 32'sh80000000;
        else
            y = q_t'(x);
        return y;
    endfunction

    function automatic wide_t rnd24(wide_t x);
        wide_t t;
        t = x + 68'sd8388608;
        return t >>> 24;
    endfunction

    function automatic q_t clamp_q(q_t x, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] lo);
        q_t y;
        y = x;
        if (y > q_t'(hi))
            y = q_t'(hi);
        if (y < q_t'(lo))
            y = q_t'(lo);
        return y;
    endfunction

    // One minus beta to the power n, with beta 0.9 or 0.999, for n up to the maximum.
    function automatic bias_tab_t gen_bias(input logic beta2);
        bias_tab_t t;
        logic [63:0] p;
        p = 64'd1 << 48;
        t[0] = '0;
        for (int i = 1; i <= HISTORY_MAX; i++)
        begin
            p = beta2 ? (p * 64'd999) / 64'd1000 : (p * 64'd9) / 64'd10;
            t[i] = 25'(((64'd1 << 48) - p + (64'd1 << 23)) >> 24);
        end
        return t;
    endfunction

    localparam bias_tab_t BIAS1 = gen_bias(1'b0);
    localparam bias_tab_t BIAS2 = gen_bias(1'b1);

endpackage
`default_nettype wire

FILE: sv/psla_if.sv
`default_nettype none
// ============================================================================
// psla_if: item and result channels
// Valid/ready channels that carry one synapse item in and one result out.
// ============================================================================
interface psla_in_if import psla_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        synapse_index;
    logic                    has_history;
    logic [HIST_W-1:0]       history_length;
    logic signed [Q_W-1:0]   weight_change;
    logic signed [Q_W-1:0]   stability_measure;
    logic signed [Q_W-1:0]   performance_metric;

    modport source (output valid, synapse_index, has_history, history_length,
                    weight_change, stability_measure, performance_metric,
                    input ready);
    modport sink (input valid, synapse_index, has_history, history_length,
                  weight_change, stability_measure, performance_metric,
                  output ready);
endinterface

interface psla_out_if import psla_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        result_index;
    logic signed [Q_W-1:0]   learning_rate;
    logic                    updated;

    modport source (output valid, result_index, learning_rate, updated, input ready);
    modport sink (input valid, result_index, learning_rate, updated, output ready);
endinterface
`default_nettype wire

FILE: sv/per_synapse_learning_rate_adapter.sv
`default_nettype none
// ============================================================================
// per_synapse_learning_rate_adapter: RMSprop / Adam / homeostatic rate update
// Keeps rate, RMS, momentum and variance per synapse in one memory and
// updates at most one entry per item through a shared multiplier, divider and root.
// ============================================================================
// After reset the block fills the state memory with its reset values and
// takes no item until that is done. One item is worked at a time. The
// shared divider yields two quotient bits per cycle and the square root
// unit one root bit per cycle. Write-back waits while the previous result
// has not been taken. A finished result waits in an output register, and
// the next item is taken while it waits.
module per_synapse_learning_rate_adapter import psla_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    psla_in_if.sink                   items,
    psla_out_if.source                results
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_CLEAR  = 5'd0;
    localparam logic [ST_W-1:0] ST_IDLE   = 5'd1;
    localparam logic [ST_W-1:0] ST_LOAD   = 5'd2;
    localparam logic [ST_W-1:0] ST_G2     = 5'd3;
    localparam logic [ST_W-1:0] ST_SKIP   = 5'd4;
    localparam logic [ST_W-1:0] ST_RMS1   = 5'd5;
    localparam logic [ST_W-1:0] ST_RMS2   = 5'd6;
    localparam logic [ST_W-1:0] ST_RMS3   = 5'd7;
    localparam logic [ST_W-1:0] ST_ADM1   = 5'd8;
    localparam logic [ST_W-1:0] ST_ADM2   = 5'd9;
    localparam logic [ST_W-1:0] ST_ADM3   = 5'd10;
    localparam logic [ST_W-1:0] ST_ADM4   = 5'd11;
    localparam logic [ST_W-1:0] ST_ADM5   = 5'd12;
    localparam logic [ST_W-1:0] ST_ADM6   = 5'd13;
    localparam logic [ST_W-1:0] ST_ADM7   = 5'd14;
    localparam logic [ST_W-1:0] ST_ADM8   = 5'd15;
    localparam logic [ST_W-1:0] ST_ADM9   = 5'd16;
    localparam logic [ST_W-1:0] ST_ADM10  = 5'd17;
    localparam logic [ST_W-1:0] ST_HOM1   = 5'd18;
    localparam logic [ST_W-1:0] ST_HOM2   = 5'd19;
    localparam logic [ST_W-1:0] ST_HOM3   = 5'd20;
    localparam logic [ST_W-1:0] ST_HOM4   = 5'd21;
    localparam logic [ST_W-1:0] ST_HOM5   = 5'd22;
    localparam logic [ST_W-1:0] ST_HOM6   = 5'd23;
    localparam logic [ST_W-1:0] ST_HOM7   = 5'd24;
    localparam logic [ST_W-1:0] ST_HOM8   = 5'd25;
    localparam logic [ST_W-1:0] ST_BLEND1 = 5'd26;
    localparam logic [ST_W-1:0] ST_BLEND2 = 5'd27;
    localparam logic [ST_W-1:0] ST_WB     = 5'd28;
    localparam logic [ST_W-1:0] ST_DIV    = 5'd29;
    localparam logic [ST_W-1:0] ST_SQRT   = 5'd30;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;
    localparam logic [CNT_W-1:0] SQRT_LAST = 5'd27;
    localparam int MEM_W = 4 * Q_W;

    // Control state
    logic [ST_W-1:0]  state_reg, state_next;
    logic [ST_W-1:0]  ret_reg, ret_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             out_valid_reg;
    logic [ALG_W-1:0] alg_reg;
    logic [CFG_W-1:0] adapt_reg, thr_reg, max_reg, min_reg, base_reg;

    // Item and entry values
    logic [IDX_W-1:0]  idx_reg;
    logic              hist_reg;
    logic [HIST_W-1:0] len_reg;
    q_t g_reg, stab_reg, perf_reg;
    q_t rate_reg, rms_reg, m_reg, v_reg;
    q_t g2_reg, mh_reg, target_reg, x_reg, sf_reg, pf_reg, lf_reg;
    opnd_t wf_reg;
    logic [1:0] k_reg;
    logic upd_reg;
    wide_t prod_reg, acc_reg;

    // Divider and root unit
    logic [63:0] dv_reg;
    logic [33:0] rem_reg, den_reg;
    logic        neg_reg;
    logic [55:0] rad_reg;
    logic [29:0] srem_reg;
    logic [27:0] root_reg;

    // Result register
    logic [IDX_W-1:0] out_idx_reg;
    q_t               out_rate_reg;
    logic             out_upd_reg;

    // State memory
    logic [MEM_W-1:0] mem [NUM_SYNAPSES];
    logic [MEM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    logic accept, wb_fire, div_start, sqrt_start, lf_needed;
    opnd_t mul_a, mul_b, fac, rate2, max_s;
    wide_t mul_p;
    logic signed [63:0] div_num, div_q;
    logic [33:0] div_den;
    logic [63:0] num_abs, dv_step;
    logic [33:0] rem_step;
    logic [31:0] sqrt_x;
    logic [29:0] srem_step;
    logic [27:0] root_step;
    logic [31:0] r2;
    logic [29:0] trial;
    logic [HIST_W-1:0] n_eff;
    q_t rms_new, vh;
    wide_t r_min, lq;

    assign accept  = items.valid && items.ready;
    assign wb_fire = (state_reg == ST_WB) && (!out_valid_reg || results.ready);

    assign items.ready           = (state_reg == ST_IDLE);
    assign results.valid         = out_valid_reg;
    assign results.result_index  = out_idx_reg;
    assign results.learning_rate = out_rate_reg;
    assign results.updated       = out_upd_reg;

    assign n_eff = (len_reg > HIST_W'(HISTORY_MAX)) ? HIST_W'(HISTORY_MAX) :
                   (len_reg == '0) ? HIST_W'(1) : len_reg;

    assign rms_new = sat32(((wide_t'(rms_reg) <<< 1) + wide_t'(rms_reg)
                           + wide_t'(g2_reg) + 68'sd2) >>> 2);
    assign div_q = neg_reg ? -$signed(dv_reg) : $signed(dv_reg);
    assign vh    = (sat32(wide_t'(div_q)) < 0) ? '0 : sat32(wide_t'(div_q));
    assign rate2 = opnd_t'(rate_reg) <<< 1;
    assign max_s = opnd_t'(max_reg);
    assign lf_needed = rate2 > max_s;
    assign r_min = (wide_t'(div_q) > wide_t'(K_09)) ? wide_t'(K_09) : wide_t'(div_q);
    assign lq    = (wide_t'(div_q) < wide_t'(K_01)) ? wide_t'(K_01) : wide_t'(div_q);

    always_comb
    begin
        case (k_reg)
            2'd0:    fac = opnd_t'(sf_reg);
            2'd1:    fac = opnd_t'(pf_reg);
            default: fac = opnd_t'(lf_reg);
        endcase
    end

    // Shared multiplier; its product is registered every cycle.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOAD:
            begin
                mul_a = opnd_t'(g_reg);
                mul_b = opnd_t'(g_reg);
            end
            ST_ADM1:
            begin
                mul_a = K_09;
                mul_b = opnd_t'(m_reg);
            end
            ST_ADM2:
            begin
                mul_a = K_01;
                mul_b = opnd_t'(g_reg);
            end
            ST_ADM3:
            begin
                mul_a = K_0999;
                mul_b = opnd_t'(v_reg);
            end
            ST_ADM4:
            begin
                mul_a = K_0001;
                mul_b = opnd_t'(g2_reg);
            end
            ST_ADM8:
            begin
                mul_a = opnd_t'(base_reg);
                mul_b = opnd_t'(mh_reg);
            end
            ST_HOM5:
            begin
                mul_a = opnd_t'(rate_reg);
                mul_b = wf_reg;
            end
            ST_HOM7:
            begin
                mul_a = opnd_t'(x_reg);
                mul_b = fac;
            end
            ST_BLEND1:
            begin
                mul_a = opnd_t'(adapt_reg);
                mul_b = opnd_t'(target_reg) - opnd_t'(rate_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        div_num = '0;
        div_den = 34'd1;
        sqrt_x  = '0;
        case (state_reg)
            ST_RMS1:
                sqrt_x = 32'(rms_new) + 32'd1;
            ST_RMS2:
            begin
                div_num = 64'(base_reg) << 24;
                div_den = 34'(root_reg) + 34'd1;
            end
            ST_ADM5:
            begin
                div_num = 64'(m_reg) <<< 24;
                div_den = 34'(BIAS1[n_eff]);
            end
            ST_ADM6:
            begin
                div_num = 64'(v_reg) <<< 24;
                div_den = 34'(BIAS2[n_eff]);
            end
            ST_ADM7:
                sqrt_x = 32'(vh);
            ST_ADM9:
            begin
                div_num = prod_reg[63:0];
                div_den = 34'(root_reg) + 34'd1;
            end
            ST_HOM1:
            begin
                div_num = 64'(stab_reg) <<< 24;
                div_den = 34'(thr_reg);
            end
            ST_HOM3:
            begin
                div_num = 64'(min_reg) << 24;
                div_den = 34'(rate_reg[31:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign num_abs = div_num[63] ? 64'(-div_num) : 64'(div_num);

    // Two restoring division steps per cycle.
    always_comb
    begin
        logic [34:0] r;
        dv_step  = dv_reg;
        rem_step = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            r = {rem_step, dv_step[63]};
            dv_step = dv_step << 1;
            if (r >= {1'b0, den_reg})
            begin
                r = r - {1'b0, den_reg};
                dv_step[0] = 1'b1;
            end
            rem_step = r[33:0];
        end
    end

    // One root bit per cycle.
    always_comb
    begin
        r2    = {srem_reg, rad_reg[55:54]};
        trial = {root_reg, 2'b01};
        if (r2 >= 32'(trial))
        begin
            srem_step = 30'(r2 - 32'(trial));
            root_step = {root_reg[26:0], 1'b1};
        end
        else
        begin
            srem_step = 30'(r2);
            root_step = {root_reg[26:0], 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_SYNAPSES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (items.valid)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_G2;
            ST_G2:
            begin
                if (alg_reg == ALG_RMSPROP)
                    state_next = hist_reg ? ST_RMS1 : ST_SKIP;
                else if (alg_reg == ALG_ADAM)
                    state_next = hist_reg ? ST_ADM1 : ST_SKIP;
                else
                    state_next = ST_HOM1;
            end
            ST_SKIP:
                state_next = ST_WB;
            ST_RMS1:
            begin
                state_next = ST_SQRT;
                ret_next   = ST_RMS2;
                cnt_next   = '0;
            end
            ST_RMS2:
            begin
                state_next = ST_DIV;
                ret_next   = ST_RMS3;
                cnt_next   = '0;
            end
            ST_RMS3:
                state_next = ST_BLEND1;
            ST_ADM1:
                state_next = ST_ADM2;
            ST_ADM2:
                state_next = ST_ADM3;
            ST_ADM3:
                state_next = ST_ADM4;
            ST_ADM4:
                state_next = ST_ADM5;
            ST_ADM5:
            begin
                state_next = ST_DIV;
                ret_next   = ST_ADM6;
                cnt_next   = '0;
            end
            ST_ADM6:
            begin
                state_next = ST_DIV;
                ret_next   = ST_ADM7;
                cnt_next   = '0;
            end
            ST_ADM7:
            begin
                state_next = ST_SQRT;
                ret_next   = ST_ADM8;
                cnt_next   = '0;
            end
            ST_ADM8:
                state_next = ST_ADM9;
            ST_ADM9:
            begin
                state_next = ST_DIV;
                ret_next   = ST_ADM10;
                cnt_next   = '0;
            end
            ST_ADM10:
                state_next = ST_BLEND1;
            ST_HOM1:
            begin
                if (thr_reg == '0)
                    state_next = ST_HOM3;
                else
                begin
                    state_next = ST_DIV;
                    ret_next   = ST_HOM2;
                    cnt_next   = '0;
                end
            end
            ST_HOM2:
                state_next = ST_HOM3;
            ST_HOM3:
            begin
                if (lf_needed)
                begin
                    state_next = ST_DIV;
                    ret_next   = ST_HOM4;
                    cnt_next   = '0;
                end
                else
                    state_next = ST_HOM5;
            end
            ST_HOM4:
                state_next = ST_HOM5;
            ST_HOM5:
                state_next = ST_HOM6;
            ST_HOM6:
                state_next = (k_reg == 2'd3) ? ST_HOM8 : ST_HOM7;
            ST_HOM7:
                state_next = ST_HOM6;
            ST_HOM8:
                state_next = ST_BLEND1;
            ST_BLEND1:
                state_next = ST_BLEND2;
            ST_BLEND2:
                state_next = ST_WB;
            ST_WB:
                if (wb_fire)
                    state_next = ST_IDLE;
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ret_reg;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                    state_next = ret_reg;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign div_start  = (state_next == ST_DIV) && (state_reg != ST_DIV);
    assign sqrt_start = (state_next == ST_SQRT) && (state_reg != ST_SQRT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            alg_reg       <= ALG_HOMEOSTATIC;
            adapt_reg     <= ADAPT_RESET;
            thr_reg       <= THR_RESET;
            max_reg       <= MAX_RESET;
            min_reg       <= MIN_RESET;
            base_reg      <= BASE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            if (wb_fire)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALGORITHM:           alg_reg   <= cfg_data[ALG_W-1:0];
                    REG_ADAPTATION_RATE:     adapt_reg <= cfg_data;
                    REG_STABILITY_THRESHOLD: thr_reg   <= cfg_data;
                    REG_MAX_RATE:            max_reg   <= cfg_data;
                    REG_MIN_RATE:            min_reg   <= cfg_data;
                    REG_BASE_RATE:           base_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (accept)
        begin
            idx_reg  <= items.synapse_index;
            hist_reg <= items.has_history;
            len_reg  <= items.history_length;
            g_reg    <= items.weight_change;
            stab_reg <= items.stability_measure;
            perf_reg <= items.performance_metric;
        end
        if (div_start)
        begin
            dv_reg  <= num_abs;
            neg_reg <= div_num[63];
            den_reg <= div_den;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dv_reg  <= dv_step;
            rem_reg <= rem_step;
        end
        if (sqrt_start)
        begin
            rad_reg  <= {sqrt_x, 24'b0};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == ST_SQRT)
        begin
            rad_reg  <= rad_reg << 2;
            srem_reg <= srem_step;
            root_reg <= root_step;
        end
        case (state_reg)
            ST_LOAD:
            begin
                rate_reg <= rd_data_reg[127:96];
                rms_reg  <= rd_data_reg[95:64];
                m_reg    <= rd_data_reg[63:32];
                v_reg    <= rd_data_reg[31:0];
            end
            ST_G2:
            begin
                g2_reg  <= sat32(rnd24(prod_reg));
                upd_reg <= 1'b1;
            end
            ST_SKIP:
                upd_reg <= 1'b0;
            ST_RMS1:
                rms_reg <= rms_new;
            ST_RMS3:
                target_reg <= sat32(wide_t'(div_q));
            ST_ADM2:
                acc_reg <= prod_reg;
            ST_ADM3:
                m_reg <= sat32(rnd24(acc_reg + prod_reg));
            ST_ADM4:
                acc_reg <= prod_reg;
            ST_ADM5:
                v_reg <= sat32(rnd24(acc_reg + prod_reg));
            ST_ADM6:
                mh_reg <= sat32(wide_t'(div_q));
            ST_ADM10:
                target_reg <= clamp_q(sat32(wide_t'(div_q)), max_reg, min_reg);
            ST_HOM1:
            begin
                wf_reg <= ((opnd_t'(g_reg) + ONE_Q) > TWO_Q) ? TWO_Q
                                                             : opnd_t'(g_reg) + ONE_Q;
                pf_reg <= sat32(wide_t'(perf_reg >>> 1) + wide_t'(ONE_Q));
                sf_reg <= q_t'(ONE_Q - K_09);
            end
            ST_HOM2:
                sf_reg <= sat32(wide_t'(ONE_Q) - r_min);
            ST_HOM3:
                lf_reg <= q_t'(ONE_Q);
            ST_HOM4:
                lf_reg <= sat32(lq);
            ST_HOM5:
                k_reg <= '0;
            ST_HOM6:
                x_reg <= sat32(rnd24(prod_reg));
            ST_HOM7:
                k_reg <= k_reg + 1'b1;
            ST_HOM8:
                target_reg <= clamp_q(x_reg, max_reg, min_reg);
            ST_BLEND2:
                rate_reg <= sat32(wide_t'(rate_reg) + rnd24(prod_reg));
            default:
            begin
            end
        endcase
        if (wb_fire)
        begin
            out_idx_reg  <= idx_reg;
            out_rate_reg <= rate_reg;
            out_upd_reg  <= upd_reg;
        end
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (wb_fire && upd_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? {RATE_RESET, 96'b0}
                                               : {rate_reg, rms_reg, m_reg, v_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[items.synapse_index];
    end

endmodule
`default_nettype wire
